/* src/card_shoe_shuffle_deal_macros.svh */
// Assertion macros shared by the card shoe RTL
`ifndef CARD_SHOE_SHUFFLE_DEAL_MACROS_SVH
`define CARD_SHOE_SHUFFLE_DEAL_MACROS_SVH

// Check that a condition implies another in the same cycle
`define CSD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle
`define CSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/csd_pkg.sv */
// Shared constants, codes and types for the card shoe
package csd_pkg;

	localparam int MAX_DECKS   = 8;
	localparam int DECK_CARDS  = 52;
	localparam int SUIT_COUNT  = 4;
	localparam int RANK_COUNT  = 13;
	localparam int STORE_DEPTH = MAX_DECKS * DECK_CARDS;
	localparam int ADDR_W      = 9;
	localparam int RND_W       = 31;
	localparam int CFG_W       = 9;

	// Operation codes
	localparam logic [1:0] OP_DEAL    = 2'd0;
	localparam logic [1:0] OP_LOAD    = 2'd1;
	localparam logic [1:0] OP_ARM     = 2'd2;
	localparam logic [1:0] OP_STEP    = 2'd3;

	// Configuration register indexes
	localparam logic REG_DECK_COUNT   = 1'b0;
	localparam logic REG_CUT_POSITION = 1'b1;

	typedef struct packed {
		logic [1:0]       op;
		logic [RND_W-1:0] random_value;
	} req_t;

	typedef struct packed {
		logic              card_valid;
		logic [3:0]        card_rank;
		logic [1:0]        card_suit;
		logic [ADDR_W-1:0] cards_left;
		logic              reshuffle_needed;
		logic              shuffle_busy;
	} rsp_t;

	typedef struct packed {
		logic [1:0] suit;
		logic [3:0] rank;
	} card_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		card_t             data;
	} ram_wr_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] addr;
	} ram_rd_t;

endpackage

/* src/csd_card_ram.sv */
// Card store: single write port, single registered read port
module csd_card_ram import csd_pkg::*; (
	input  logic    clk,
	input  ram_wr_t wr,
	input  ram_rd_t rd,
	output card_t   rdata
);

	card_t mem [STORE_DEPTH];

	// Write the addressed entry
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Register the read data; hold it between reads
	always_ff @(posedge clk) begin
		if (rd.re) begin
			rdata <= mem[rd.addr];
		end
	end

endmodule

/* src/csd_mod_unit.sv */
// Remainder unit: 31-bit word modulo a 9-bit count, four bits per cycle
module csd_mod_unit import csd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RND_W-1:0]  dividend,
	input  logic [ADDR_W-1:0] divisor,
	output logic              done,
	output logic [ADDR_W-1:0] remainder
);

	logic [RND_W:0]    dividend_q;
	logic [ADDR_W-1:0] div_q;
	logic [ADDR_W-1:0] rem_q;
	logic [2:0]        cnt_q;
	logic              run_q;
	logic              done_q;
	logic [ADDR_W-1:0] rem_next;

	// Restoring steps over the next four dividend bits, top bit first
	always_comb begin
		logic [ADDR_W:0] t;
		logic [ADDR_W-1:0] r;
		r = rem_q;
		for (int k = 0; k < 4; k++) begin
			t = {r, dividend_q[RND_W-k]};
			if (t >= {1'b0, div_q}) begin
				t = t - {1'b0, div_q};
			end
			r = t[ADDR_W-1:0];
		end
		rem_next = r;
	end

	// Load the operands, then advance one chunk a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dividend_q <= '0;
			div_q      <= '0;
			rem_q      <= '0;
			cnt_q      <= '0;
			run_q      <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dividend_q <= {1'b0, dividend};
				div_q      <= divisor;
				rem_q      <= '0;
				cnt_q      <= '0;
				run_q      <= 1'b1;
			end else if (run_q) begin
				rem_q      <= rem_next;
				dividend_q <= dividend_q << 4;
				cnt_q      <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

/* src/card_shoe_shuffle_deal.sv */
// Card shoe top level: command sequencer around the card store and remainder unit
//
//   channel   handshake             payload
//   request   start / busy          req   (op, random_value)
//   result    done (one cycle)      rsp   (card, cards_left, flags)
//   config    cfg_we                cfg_index, cfg_data
//
// A deal or an arm goes from the accepting cycle straight to the done state.
// A shuffle step runs the remainder unit over eight chunks of four bits of the random
// word, then reads the partner, makes two writes to the card store and ends in the
// done state. A load makes one write a card, then arms the shuffle.
// Reset clears all control state; the card store is not cleared.
// The receiver cannot stall: each result shows for one cycle with done high.
module card_shoe_shuffle_deal import csd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             req,
	output logic             done,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

`include "card_shoe_shuffle_deal_macros.svh"

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FILL = 3'd1;
	localparam logic [2:0] S_MOD  = 3'd2;
	localparam logic [2:0] S_RJ   = 3'd3;
	localparam logic [2:0] S_WI   = 3'd4;
	localparam logic [2:0] S_WJ   = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]        state_q;
	logic [3:0]        deck_count_q;
	logic [ADDR_W-1:0] cut_position_q;
	logic [ADDR_W-1:0] shoe_size_q;
	logic [ADDR_W-1:0] deal_position_q;
	logic [ADDR_W-1:0] shuffle_index_q;
	logic              shuffle_active_q;
	logic [ADDR_W-1:0] fill_addr_q;
	logic [3:0]        fill_rank_q;
	logic [1:0]        fill_suit_q;
	logic              card_valid_q;
	logic [ADDR_W-1:0] swap_j_q;
	card_t             card_i_q;

	ram_wr_t           ram_wr;
	ram_rd_t           ram_rd;
	card_t             ram_rdata;
	logic              mod_start;
	logic              mod_done;
	logic [ADDR_W-1:0] mod_rem;

	logic              accept;
	logic              stop_reached;
	logic              deal_ok;
	logic              step_ok;
	logic [3:0]        decks_sat;
	logic [ADDR_W-1:0] shoe_of_decks;

	csd_card_ram u_ram (
		.clk   (clk),
		.wr    (ram_wr),
		.rd    (ram_rd),
		.rdata (ram_rdata)
	);

	csd_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (req.random_value),
		.divisor   (ADDR_W'(shuffle_index_q + 9'd1)),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	// Decode the request and the stop conditions
	assign accept       = start && !busy;
	assign stop_reached = (deal_position_q >= cut_position_q) ||
		(deal_position_q >= shoe_size_q);
	assign deal_ok      = !shuffle_active_q && !stop_reached &&
		(deal_position_q < ADDR_W'(STORE_DEPTH));
	assign step_ok      = shuffle_active_q && (shuffle_index_q != '0) &&
		(shuffle_index_q < ADDR_W'(STORE_DEPTH));
	assign decks_sat    = (deck_count_q > 4'(MAX_DECKS)) ? 4'(MAX_DECKS) : deck_count_q;
	assign shoe_of_decks = ADDR_W'(decks_sat) * ADDR_W'(DECK_CARDS);
	assign mod_start    = accept && (req.op == OP_STEP) && step_ok;

	// Drive the store ports from the sequencer state
	always_comb begin
		ram_wr = '0;
		ram_rd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (req.op == OP_DEAL) && deal_ok) begin
					ram_rd.re   = 1'b1;
					ram_rd.addr = deal_position_q;
				end else if (mod_start) begin
					ram_rd.re   = 1'b1;
					ram_rd.addr = shuffle_index_q;
				end
			end
			S_FILL: begin
				ram_wr.we        = (fill_addr_q != shoe_size_q);
				ram_wr.addr      = fill_addr_q;
				ram_wr.data.suit = fill_suit_q;
				ram_wr.data.rank = fill_rank_q;
			end
			S_RJ: begin
				ram_rd.re   = 1'b1;
				ram_rd.addr = swap_j_q;
			end
			S_WI: begin
				ram_wr.we   = 1'b1;
				ram_wr.addr = shuffle_index_q;
				ram_wr.data = ram_rdata;
			end
			S_WJ: begin
				ram_wr.we   = 1'b1;
				ram_wr.addr = swap_j_q;
				ram_wr.data = card_i_q;
			end
			S_MOD, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deck_count_q   <= 4'd6;
			cut_position_q <= 9'd234;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DECK_COUNT:   deck_count_q   <= cfg_data[3:0];
				REG_CUT_POSITION: cut_position_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequence each request and update the shoe state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			shoe_size_q      <= '0;
			deal_position_q  <= '0;
			shuffle_index_q  <= '0;
			shuffle_active_q <= 1'b0;
			fill_addr_q      <= '0;
			fill_rank_q      <= 4'd1;
			fill_suit_q      <= '0;
			card_valid_q     <= 1'b0;
			swap_j_q         <= '0;
			card_i_q         <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						card_valid_q <= 1'b0;
						state_q      <= S_DONE;
						case (req.op)
							OP_DEAL: begin
								if (deal_ok) begin
									card_valid_q    <= 1'b1;
									deal_position_q <= deal_position_q + 9'd1;
								end
							end
							OP_LOAD: begin
								shoe_size_q     <= shoe_of_decks;
								deal_position_q <= '0;
								fill_addr_q     <= '0;
								fill_rank_q     <= 4'd1;
								fill_suit_q     <= '0;
								state_q         <= S_FILL;
							end
							OP_ARM: begin
								if (shoe_size_q > 9'd1) begin
									shuffle_index_q  <= shoe_size_q - 9'd1;
									shuffle_active_q <= 1'b1;
								end else begin
									shuffle_index_q  <= '0;
									shuffle_active_q <= 1'b0;
									deal_position_q  <= '0;
								end
							end
							default: begin
								if (step_ok) begin
									state_q <= S_MOD;
								end else begin
									shuffle_active_q <= 1'b0;
								end
							end
						endcase
					end
				end
				S_FILL: begin
					if (fill_addr_q == shoe_size_q) begin
						// Arm the shuffle at the last card
						if (shoe_size_q > 9'd1) begin
							shuffle_index_q  <= shoe_size_q - 9'd1;
							shuffle_active_q <= 1'b1;
						end else begin
							shuffle_index_q  <= '0;
							shuffle_active_q <= 1'b0;
						end
						state_q <= S_DONE;
					end else begin
						fill_addr_q <= fill_addr_q + 9'd1;
						if (fill_rank_q == 4'(RANK_COUNT)) begin
							fill_rank_q <= 4'd1;
							fill_suit_q <= fill_suit_q + 2'd1;
						end else begin
							fill_rank_q <= fill_rank_q + 4'd1;
						end
					end
				end
				S_MOD: begin
					// Hold the card at the top index while the remainder runs
					card_i_q <= ram_rdata;
					if (mod_done) begin
						swap_j_q <= mod_rem;
						state_q  <= S_RJ;
					end
				end
				S_RJ: begin
					state_q <= S_WI;
				end
				S_WI: begin
					state_q <= S_WJ;
				end
				S_WJ: begin
					shuffle_index_q <= shuffle_index_q - 9'd1;
					if (shuffle_index_q == 9'd1) begin
						shuffle_active_q <= 1'b0;
						deal_position_q  <= '0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Present the result from the updated state
	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	always_comb begin
		rsp.card_valid       = card_valid_q;
		rsp.card_rank        = card_valid_q ? ram_rdata.rank : 4'd0;
		rsp.card_suit        = card_valid_q ? ram_rdata.suit : 2'd0;
		rsp.cards_left       = shoe_size_q - deal_position_q;
		rsp.reshuffle_needed = stop_reached;
		rsp.shuffle_busy     = shuffle_active_q;
	end

	`CSD_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done, "result strobe held for more than one cycle")
	`CSD_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy, "request accepted but sequencer stayed idle")
	`CSD_ASSERT_SAME(a_no_deal_shuffling, clk, arst_n, done && rsp.card_valid, !rsp.shuffle_busy, "card dealt while shuffle still running")
	`CSD_ASSERT_SAME(a_partner_range, clk, arst_n, state_q == S_RJ, swap_j_q <= shuffle_index_q, "swap partner beyond shuffle index")

endmodule

/* verif/tb_card_shoe_shuffle_deal.sv */
// Self-checking testbench for the card shoe: load, shuffle, deal and cut card stop
module tb_card_shoe_shuffle_deal;
	timeunit 1ns;
	timeprecision 1ps;
	import csd_pkg::*;

	// Tracks the shoe contents and pointers, and holds the responses still awaited
	class shoe_tracker;
		card_t       store [STORE_DEPTH];
		int unsigned deal_pos;
		int unsigned shuf_idx;
		int unsigned shoe_n;
		int unsigned decks;
		int unsigned cut;
		bit          shuf_on;
		rsp_t        awaited_rsp [$];
		int unsigned failures;

		function new();
			deal_pos = 0;
			shuf_idx = 0;
			shuf_on  = 1'b0;
			shoe_n   = 0;
			decks    = 6;
			cut      = 234;
			failures = 0;
			foreach (store[k])
				store[k] = '0;
		endfunction

		function void write_reg(logic idx, logic [CFG_W-1:0] data);
			if (idx == REG_DECK_COUNT) begin
				decks = 32'(data[3:0]);
			end else begin
				cut = 32'(data);
			end
		endfunction

		function bit at_stop();
			return deal_pos >= cut || deal_pos >= shoe_n;
		endfunction

		// Start a shuffle at the top, or finish at once on a tiny shoe
		function void arm_shuffle();
			if (shoe_n > 1) begin
				shuf_idx = shoe_n - 1;
				shuf_on  = 1'b1;
			end else begin
				shuf_idx = 0;
				shuf_on  = 1'b0;
				deal_pos = 0;
			end
		endfunction

		function void note_request(req_t r);
			rsp_t        want;
			card_t       c;
			int unsigned n, pick, d, s, rk;
			want = '0;
			case (r.op)
				OP_DEAL: begin
					if (!shuf_on && !at_stop() && deal_pos < STORE_DEPTH) begin
						c = store[deal_pos];
						want.card_valid = 1'b1;
						want.card_rank  = c.rank;
						want.card_suit  = c.suit;
						deal_pos++;
					end
				end
				OP_LOAD: begin
					n = (decks > MAX_DECKS) ? MAX_DECKS : decks;
					shoe_n = 0;
					for (d = 0; d < n; d++)
						for (s = 0; s < SUIT_COUNT; s++)
							for (rk = 1; rk <= RANK_COUNT; rk++) begin
								store[shoe_n] = '{suit: s[1:0], rank: rk[3:0]};
								shoe_n++;
							end
					deal_pos = 0;
					arm_shuffle();
				end
				OP_ARM: arm_shuffle();
				OP_STEP: begin
					if (!shuf_on || shuf_idx == 0 || shuf_idx >= STORE_DEPTH) begin
						shuf_on = 1'b0;
					end else begin
						// swap entry i with its partner, then step i down
						pick = r.random_value % (shuf_idx + 1);
						c = store[shuf_idx];
						store[shuf_idx] = store[pick];
						store[pick] = c;
						shuf_idx--;
						if (shuf_idx == 0) begin
							shuf_on  = 1'b0;
							deal_pos = 0;
						end
					end
				end
			endcase
			want.cards_left       = ADDR_W'(shoe_n - deal_pos);
			want.reshuffle_needed = at_stop();
			want.shuffle_busy     = shuf_on;
			awaited_rsp.push_back(want);
		endfunction

		function void compare(string fld, logic [8:0] want, logic [8:0] got);
			if (want !== got) begin
				failures++;
				if (failures <= 200)
					$display("%0t: %s expected %0d got %0d", $time, fld, want, got);
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (awaited_rsp.size() == 0) begin
				failures++;
				$display("%0t: response with no request waiting, expected none got %p",
					$time, got);
				return;
			end
			want = awaited_rsp.pop_front();
			compare("card_valid", 9'(want.card_valid), 9'(got.card_valid));
			compare("card_rank", 9'(want.card_rank), 9'(got.card_rank));
			compare("card_suit", 9'(want.card_suit), 9'(got.card_suit));
			compare("cards_left", want.cards_left, got.cards_left);
			compare("reshuffle_needed", 9'(want.reshuffle_needed),
				9'(got.reshuffle_needed));
			compare("shuffle_busy", 9'(want.shuffle_busy), 9'(got.shuffle_busy));
		endfunction

		function int unsigned outstanding();
			return awaited_rsp.size();
		endfunction

		function void flush();
			if (awaited_rsp.size() != 0) begin
				failures++;
				$display("%0t: %0d responses expected %0d got 0", $time,
					awaited_rsp.size(), awaited_rsp.size());
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	req_t             req;
	logic             done;
	rsp_t             rsp;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;

	shoe_tracker board = new;
	int unsigned burst_left;
	int unsigned items_sent;

	card_shoe_shuffle_deal dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// Observe register writes, accepted requests and response strobes
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				board.write_reg(cfg_index, cfg_data);
			if (start && !busy)
				board.note_request(req);
			if (done)
				board.check_result(rsp);
		end
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#40_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [RND_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return RND_W'($urandom_range(0, 1000));
			default: return RND_W'($urandom);
		endcase
	endfunction

	// Issue one request; the sender works in bursts separated by random gaps
	task automatic send_cmd(logic [1:0] op, logic [RND_W-1:0] rnd);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		burst_left--;
		start <= 1'b1;
		req   <= '{op: op, random_value: rnd};
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
	endtask

	// Hold the sender until every awaited response has come back
	task automatic drain();
		start <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (board.outstanding() != 0) @(posedge clk);
	endtask

	task automatic write_regs(logic [3:0] decks, logic [CFG_W-1:0] cut_pos);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DECK_COUNT;
		cfg_data  <= CFG_W'(decks);
		@(posedge clk);
		cfg_index <= REG_CUT_POSITION;
		cfg_data  <= cut_pos;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_cut(logic [CFG_W-1:0] cut_pos);
		cfg_we    <= 1'b1;
		cfg_index <= REG_CUT_POSITION;
		cfg_data  <= cut_pos;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned decks, shoe, last_shoe, cut_pos, steps_left;
		int unsigned dealt, stop_at, extra, round, pick;
		int          change_at;
		bit          reuse;
		bit          rearmed;

		arst_n    <= 1'b0;
		start     <= 1'b0;
		req       <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_DECK_COUNT;
		cfg_data  <= '0;
		burst_left = 0;
		items_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Empty shoe after reset: deal, idle shuffle step and arm do nothing
		send_cmd(OP_DEAL, '0);
		send_cmd(OP_STEP, '1);
		send_cmd(OP_ARM, '0);

		// Deck count zero with the cut at the far end
		drain();
		write_regs(4'd0, CFG_W'(416));
		send_cmd(OP_LOAD, rand_word());
		send_cmd(OP_DEAL, '0);
		send_cmd(OP_STEP, rand_word());

		// Saturated deck count, deal and re-arm while shuffling
		drain();
		write_regs(4'd15, '0);
		send_cmd(OP_LOAD, '0);
		send_cmd(OP_STEP, '1);
		send_cmd(OP_STEP, '0);
		send_cmd(OP_DEAL, '1);
		send_cmd(OP_ARM, '0);
		send_cmd(OP_STEP, 31'h2AAA_AAAA);

		// Load while a shuffle is running restarts it on the new shoe
		drain();
		write_regs(4'd1, CFG_W'(52));
		send_cmd(OP_LOAD, 31'h5555_5555);
		send_cmd(OP_STEP, 31'h5555_5555);

		// Random rounds: configure, load or re-arm, shuffle through, deal to the cut
		round = 0;
		last_shoe = 0;
		while (items_sent < 1500) begin
			if (round == 1) begin
				decks = $urandom_range(8, 15);
			end else begin
				pick = $urandom_range(0, 9);
				decks = (pick == 0) ? 0 : (pick == 9) ? 3 : $urandom_range(1, 2);
			end
			reuse = (round > 1) && ($urandom_range(0, 3) == 0);
			shoe = reuse ? last_shoe : ((decks > MAX_DECKS) ? MAX_DECKS : decks) * DECK_CARDS;
			case ($urandom_range(0, 9))
				0:       cut_pos = 0;
				1:       cut_pos = 416;
				2:       cut_pos = $urandom_range(0, 416);
				default: cut_pos = $urandom_range(0, shoe);
			endcase
			drain();
			write_regs(decks[3:0], CFG_W'(cut_pos));
			send_cmd(reuse ? OP_ARM : OP_LOAD, rand_word());

			// shuffle, with the odd refused deal or one restart thrown in
			steps_left = (shoe > 1) ? shoe - 1 : 0;
			rearmed = 1'b0;
			while (steps_left > 0) begin
				pick = $urandom_range(0, 39);
				if (pick == 0) begin
					send_cmd(OP_DEAL, rand_word());
				end else if (pick == 1 && !rearmed) begin
					send_cmd(OP_ARM, rand_word());
					steps_left = shoe - 1;
					rearmed = 1'b1;
				end else begin
					send_cmd(OP_STEP, rand_word());
					steps_left--;
				end
			end

			// deal up to the stop and one to three past it, sometimes moving the cut part way through
			dealt = 0;
			stop_at = (cut_pos < shoe) ? cut_pos : shoe;
			change_at = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, stop_at)) : -1;
			extra = $urandom_range(1, 3);
			while (dealt < stop_at || extra > 0) begin
				if (change_at >= 0 && dealt == change_at) begin
					drain();
					cut_pos = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 416)
						: $urandom_range(0, shoe);
					write_cut(CFG_W'(cut_pos));
					stop_at = (cut_pos < shoe) ? cut_pos : shoe;
					change_at = -1;
				end else if ($urandom_range(0, 49) == 0) begin
					send_cmd(OP_STEP, rand_word());
				end else begin
					send_cmd(OP_DEAL, rand_word());
					if (dealt < stop_at)
						dealt++;
					else
						extra--;
				end
			end
			last_shoe = shoe;
			round++;
		end

		drain();
		repeat (20) @(posedge clk);
		board.flush();
		if (board.failures == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
